[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for checkers clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// delayed implication
`define ASSERT_DLY2(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("assertion failed");

`endif

[sv/fqpr_pkg.sv]
// ----------------------------------------------------------------------------
// fqpr_pkg
// Types and constants shared by the queue controller, datapath and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fqpr_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int OFFS_W = 4;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_ENQ  = 2'd0,
        REQ_DEQ  = 2'd1,
        REQ_PEEK = 2'd2,
        REQ_REV  = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        req_kind_t           req_type;
        logic [DATA_W-1:0]   data_in;
        logic [OFFS_W-1:0]   offset;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0]   data_out;
        logic [CNT_W-1:0]    item_count;
        status_t             status;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctl_cmd_t;

endpackage

`default_nettype wire

[sv/fifo_queue_peek_reverse_unit.sv]
// ----------------------------------------------------------------------------
// fifo_queue_peek_reverse_unit
// Bounded queue with enqueue, dequeue, indexed peek and one-step reversal.
//
//   channel   signals              dir   beat marked by
//   request   start, busy, req     in    start && !busy at the clock edge
//   result    done, rsp            out   done, high for one cycle
//
// A request accepted at one edge runs the execute state, which also registers
// the ring store read; done and rsp follow in the next cycle. busy is low again
// in the result cycle, so a new request may enter then. Reset clears the queue
// to empty and forward order; results cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_queue_peek_reverse_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire fqpr_pkg::req_t req,
    output logic                done,
    output fqpr_pkg::rsp_t      rsp
);
    import fqpr_pkg::*;

    ctl_cmd_t cmd;

    fqpr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    fqpr_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

[sv/fqpr_ctrl.sv]
// ----------------------------------------------------------------------------
// fqpr_ctrl
// Request sequencer: accept a beat, run the execute state, strobe the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fqpr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    output fqpr_pkg::ctl_cmd_t     cmd
);
    import fqpr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        unique case (state_reg)
            S_EXEC:  state_next = S_RESP;
            S_IDLE,
            S_RESP:  state_next = accept ? S_EXEC : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next == S_EXEC);
            done_reg  <= (state_next == S_RESP);
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign cmd.load = accept;
    assign cmd.exec = (state_reg == S_EXEC);

endmodule

`default_nettype wire

[sv/fqpr_dp.sv]
// ----------------------------------------------------------------------------
// fqpr_dp
// Ring store, base/fill/direction registers and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fqpr_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fqpr_pkg::ctl_cmd_t cmd,
    input  wire fqpr_pkg::req_t     req,
    output fqpr_pkg::rsp_t          rsp
);
    import fqpr_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] mem_q_reg;

    req_t              req_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] base_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic              flag_reg;
    logic              flag_next;
    logic [CNT_W-1:0]  count_reg;
    status_t           status_reg;
    status_t           status_next;
    logic              rd_ok_reg;

    logic [ADDR_W-1:0] addr;
    logic              mem_we;
    logic              mem_re;
    logic              is_empty;
    logic              is_full;
    logic [CNT_W-1:0]  fill_m1;

    function automatic logic [ADDR_W-1:0] slot_of(
        input logic [ADDR_W-1:0] base,
        input logic              rev,
        input logic [ADDR_W-1:0] k
    );
        return rev ? (base - k) : (base + k);
    endfunction

    assign is_empty = (fill_reg == '0);
    assign is_full  = (fill_reg == CNT_W'(DEPTH));
    assign fill_m1  = fill_reg - CNT_W'(1);

    always_comb
    begin
        addr        = slot_of(base_reg, flag_reg, '0);
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        base_next   = base_reg;
        fill_next   = fill_reg;
        flag_next   = flag_reg;
        status_next = ST_OK;
        unique case (req_reg.req_type)
            REQ_ENQ:
            begin
                addr = slot_of(base_reg, flag_reg, fill_reg[ADDR_W-1:0]);
                if (is_full)
                    status_next = ST_FULL;
                else
                begin
                    mem_we    = 1'b1;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            REQ_DEQ:
            begin
                if (is_empty)
                    status_next = ST_EMPTY;
                else
                begin
                    mem_re    = 1'b1;
                    base_next = slot_of(base_reg, flag_reg, ADDR_W'(1));
                    fill_next = fill_m1;
                end
            end
            REQ_PEEK:
            begin
                addr = slot_of(base_reg, flag_reg, ADDR_W'(req_reg.offset));
                if (CNT_W'(req_reg.offset) >= fill_reg)
                    status_next = ST_RANGE;
                else
                    mem_re = 1'b1;
            end
            REQ_REV:
            begin
                if (!is_empty)
                    base_next = slot_of(base_reg, flag_reg, fill_m1[ADDR_W-1:0]);
                flag_next = !flag_reg;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.exec)
        begin
            count_reg  <= fill_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
            mem[addr] <= req_reg.data_in;
        if (cmd.exec && mem_re)
            mem_q_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            fill_reg  <= '0;
            flag_reg  <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            base_reg  <= base_next;
            fill_reg  <= fill_next;
            flag_reg  <= flag_next;
            rd_ok_reg <= mem_re;
        end
    end

    assign rsp.data_out   = rd_ok_reg ? mem_q_reg : '0;
    assign rsp.item_count = count_reg;
    assign rsp.status     = status_reg;

endmodule

`default_nettype wire

[sv/fqpr_chk.sv]
// ----------------------------------------------------------------------------
// fqpr_chk
// Port-level checks on request/result timing and result contents.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fqpr_chk (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic           busy,
    input  wire logic           done,
    input  wire fqpr_pkg::rsp_t rsp
);
    import fqpr_pkg::*;

    logic accept;

    assign accept = start && !busy;

    `ASSERT_DLY2(a_result_follows, accept, done)
    `ASSERT_NEXT(a_busy_then_done, busy, done && !busy)
    `ASSERT_NEXT(a_single_strobe, done, !done)
    `ASSERT_IMPL(a_count_bound, done, rsp.item_count <= CNT_W'(DEPTH))
    `ASSERT_IMPL(a_error_no_data, done && (rsp.status != ST_OK), rsp.data_out == '0)

endmodule

bind fifo_queue_peek_reverse_unit fqpr_chk u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire
